// File: src/hds_pkg.sv
// Shared constants, types and datapath control for the heat diffusion stencil grid.
`default_nettype none

package hds_pkg;

    // Grid geometry
    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    // Field and register widths
    localparam int TEMP_W     = 7;
    localparam int STEPS_W    = 8;
    localparam int GAIN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8    = 2'd1;

    localparam logic [STEPS_W-1:0] TIME_STEPS_RST = 8'd9;
    localparam logic [GAIN_W-1:0]  GAIN_Q8_RST    = 7'd64;

    // Datapath widths: sum of four cells, signed Laplacian, gain product
    localparam int Q_SHIFT = 8;
    localparam int ACC_W   = TEMP_W + 2;
    localparam int DIFF_W  = TEMP_W + 3;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int SH_W    = PROD_W - Q_SHIFT;
    localparam int VAL_W   = SH_W + 1;

    typedef logic [TEMP_W-1:0] temp_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Sequencer strobes into the shared arithmetic unit
    typedef struct packed {
        logic acc_load;
        logic acc_add;
        logic diff_en;
        logic mul_en;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// File: src/hds_ifs.sv
// Request channel interfaces for grid load and result streams.
`default_nettype none

interface hds_in_if;
    logic                      valid;
    logic                      ready;
    logic [hds_pkg::TEMP_W-1:0] cell_temp;
    logic                      load_last;

    modport source (output valid, output cell_temp, output load_last, input ready);
    modport sink   (input valid, input cell_temp, input load_last, output ready);
endinterface

interface hds_out_if;
    logic                      valid;
    logic                      ready;
    logic [hds_pkg::TEMP_W-1:0] out_temp;
    logic                      out_last;

    modport source (output valid, output out_temp, output out_last, input ready);
    modport sink   (input valid, input out_temp, input out_last, output ready);
endinterface

`default_nettype wire

// File: src/hds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/hds_alu.sv
// Shared stencil arithmetic: neighbor sum, Laplacian, gain product, floor shift and clamp.
`default_nettype none

module hds_alu (
    input  wire logic                          clk,
    input  wire hds_pkg::alu_ctrl_t            ctrl,
    input  wire hds_pkg::temp_t                rdata,
    input  wire logic [hds_pkg::GAIN_W-1:0]    gain,
    output hds_pkg::temp_t                     result
);

    logic        [hds_pkg::ACC_W-1:0]  acc_reg;
    logic        [hds_pkg::ACC_W-1:0]  acc_next;
    hds_pkg::temp_t                    old_reg;
    logic signed [hds_pkg::DIFF_W-1:0] diff_reg;
    logic signed [hds_pkg::DIFF_W-1:0] diff_next;
    logic signed [hds_pkg::PROD_W-1:0] prod_reg;
    logic signed [hds_pkg::PROD_W-1:0] prod_next;
    logic signed [hds_pkg::SH_W-1:0]   shifted;
    logic signed [hds_pkg::VAL_W-1:0]  val;

    // One adder keeps the running sum; a separate subtractor forms the minus-four-times-center term
    always_comb
    begin
        acc_next  = hds_pkg::ACC_W'(rdata);
        if (ctrl.acc_add)
        begin
            acc_next = acc_reg + hds_pkg::ACC_W'(rdata);
        end
        diff_next = hds_pkg::DIFF_W'(acc_reg) - hds_pkg::DIFF_W'({rdata, 2'b00});
        prod_next = $signed({1'b0, gain}) * diff_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load || ctrl.acc_add)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.diff_en)
        begin
            old_reg  <= rdata;
            diff_reg <= diff_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Dropping the low bits of a signed value rounds toward minus infinity
    assign shifted = prod_reg[hds_pkg::PROD_W-1:hds_pkg::Q_SHIFT];

    always_comb
    begin
        val = {shifted[hds_pkg::SH_W-1], shifted}
            + $signed({{(hds_pkg::VAL_W - hds_pkg::TEMP_W){1'b0}}, old_reg});
        priority if (val[hds_pkg::VAL_W-1])
        begin
            result = '0;
        end
        else if (val[hds_pkg::VAL_W-2:hds_pkg::TEMP_W] != '0)
        begin
            result = '1;
        end
        else
        begin
            result = val[hds_pkg::TEMP_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: src/heat_diffusion_stencil_grid.sv
// Top level: grid load, iterated five-point heat diffusion and row-major grid readout.
//
//  channel   dir  handshake       payload
//  in_ch     in   valid / ready   cell_temp[6:0], load_last
//  out_ch    out  valid / ready   out_temp[6:0], out_last
//  cfg       in   cfg_we          cfg_index[1:0], cfg_data[7:0]
//
//  Loading takes one cycle per cell; the request with load_last starts the run.
//  Each diffusion step walks every interior cell through the phases N, S, W, E, C, DIFF,
//  MUL and WR, set by the single read port of the source grid (five reads per cell) and the shared unit.
//  Readout fetches each cell through the registered RAM read before offering it, and holds it under stall.
//  in_ch.ready is low from load_last until the last result is taken.
//  Reset returns control and configuration to their reset values only; the grid RAMs are not cleared.
`default_nettype none

module heat_diffusion_stencil_grid (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    hds_in_if.sink                                  in_ch,
    hds_out_if.source                               out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_STEP    = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    localparam logic [2:0] PH_N    = 3'd0;
    localparam logic [2:0] PH_S    = 3'd1;
    localparam logic [2:0] PH_W    = 3'd2;
    localparam logic [2:0] PH_E    = 3'd3;
    localparam logic [2:0] PH_C    = 3'd4;
    localparam logic [2:0] PH_DIFF = 3'd5;
    localparam logic [2:0] PH_MUL  = 3'd6;
    localparam logic [2:0] PH_WR   = 3'd7;

    localparam hds_pkg::addr_t ADDR_COLS  = hds_pkg::ADDR_W'(hds_pkg::COLS);
    localparam hds_pkg::addr_t ADDR_FIRST = hds_pkg::ADDR_W'(hds_pkg::COLS + 1);
    localparam hds_pkg::addr_t ADDR_LAST  = hds_pkg::ADDR_W'(hds_pkg::CELLS - 1);
    localparam logic [hds_pkg::ROW_W-1:0] ROW_END = hds_pkg::ROW_W'(hds_pkg::ROWS - 2);
    localparam logic [hds_pkg::COL_W-1:0] COL_END = hds_pkg::COL_W'(hds_pkg::COLS - 2);

    logic [1:0]                    state_reg, state_next;
    logic [2:0]                    phase_reg, phase_next;
    hds_pkg::addr_t                p_reg, p_next;
    logic [hds_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [hds_pkg::COL_W-1:0]     col_reg, col_next;
    logic [hds_pkg::STEPS_W-1:0]   step_cnt_reg, step_cnt_next;
    hds_pkg::addr_t                load_idx_reg, load_idx_next;
    hds_pkg::addr_t                emit_idx_reg, emit_idx_next;
    logic [hds_pkg::STEPS_W-1:0]   time_steps_reg, time_steps_next;
    logic [hds_pkg::GAIN_W-1:0]    gain_reg, gain_next;

    logic               in_acc;
    logic               out_acc;
    logic               src_odd;
    hds_pkg::addr_t     rd_addr;
    hds_pkg::addr_t     wr_addr;
    hds_pkg::temp_t     wr_data;
    logic               load_we;
    logic               step_we;
    hds_pkg::temp_t     rdata_even;
    hds_pkg::temp_t     rdata_odd;
    hds_pkg::temp_t     src_data;
    hds_pkg::temp_t     alu_result;
    hds_pkg::alu_ctrl_t alu_ctrl;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    // Step k reads the even grid when k is even; after the run this selects the final grid
    assign src_odd  = step_cnt_reg[0];
    assign src_data = src_odd ? rdata_odd : rdata_even;

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = (state_reg == ST_EMIT);
    assign out_ch.out_temp = src_data;
    assign out_ch.out_last = (emit_idx_reg == ADDR_LAST);

    assign load_we = in_acc;
    assign step_we = (state_reg == ST_STEP) && (phase_reg == PH_WR);
    assign wr_addr = load_we ? load_idx_reg : p_reg;
    assign wr_data = load_we ? in_ch.cell_temp : alu_result;

    always_comb
    begin
        alu_ctrl.acc_load = (state_reg == ST_STEP) && (phase_reg == PH_S);
        alu_ctrl.acc_add  = (state_reg == ST_STEP)
                         && (phase_reg == PH_W || phase_reg == PH_E || phase_reg == PH_C);
        alu_ctrl.diff_en  = (state_reg == ST_STEP) && (phase_reg == PH_DIFF);
        alu_ctrl.mul_en   = (state_reg == ST_STEP) && (phase_reg == PH_MUL);
    end

    // Neighbor fetch order: north, south, west, east, center
    always_comb
    begin
        rd_addr = emit_idx_reg;
        if (state_reg == ST_STEP)
        begin
            unique case (phase_reg)
                PH_N:    rd_addr = p_reg - ADDR_COLS;
                PH_S:    rd_addr = p_reg + ADDR_COLS;
                PH_W:    rd_addr = p_reg - 1'b1;
                PH_E:    rd_addr = p_reg + 1'b1;
                default: rd_addr = p_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        p_next          = p_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        step_cnt_next   = step_cnt_reg;
        load_idx_next   = load_idx_reg;
        emit_idx_next   = emit_idx_reg;
        time_steps_next = time_steps_reg;
        gain_next       = gain_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                hds_pkg::CFG_TIME_STEPS: time_steps_next = cfg_data[hds_pkg::STEPS_W-1:0];
                hds_pkg::CFG_GAIN_Q8:    gain_next = cfg_data[hds_pkg::GAIN_W-1:0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    load_idx_next = (load_idx_reg == ADDR_LAST) ? '0 : load_idx_reg + 1'b1;
                    if (in_ch.load_last)
                    begin
                        load_idx_next = '0;
                        step_cnt_next = '0;
                        emit_idx_next = '0;
                        phase_next    = PH_N;
                        p_next        = ADDR_FIRST;
                        row_next      = hds_pkg::ROW_W'(1);
                        col_next      = hds_pkg::COL_W'(1);
                        state_next    = (time_steps_reg == '0) ? ST_EMIT_RD : ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PH_WR)
                begin
                    if (col_reg != COL_END)
                    begin
                        col_next = col_reg + 1'b1;
                        p_next   = p_reg + 1'b1;
                    end
                    else if (row_reg != ROW_END)
                    begin
                        // skip the east border of this row and the west border of the next
                        row_next = row_reg + 1'b1;
                        col_next = hds_pkg::COL_W'(1);
                        p_next   = p_reg + hds_pkg::ADDR_W'(3);
                    end
                    else
                    begin
                        step_cnt_next = step_cnt_reg + 1'b1;
                        row_next      = hds_pkg::ROW_W'(1);
                        col_next      = hds_pkg::COL_W'(1);
                        p_next        = ADDR_FIRST;
                        if (step_cnt_reg + 1'b1 == time_steps_reg)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (emit_idx_reg == ADDR_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_N;
            p_reg          <= ADDR_FIRST;
            row_reg        <= hds_pkg::ROW_W'(1);
            col_reg        <= hds_pkg::COL_W'(1);
            step_cnt_reg   <= '0;
            load_idx_reg   <= '0;
            emit_idx_reg   <= '0;
            time_steps_reg <= hds_pkg::TIME_STEPS_RST;
            gain_reg       <= hds_pkg::GAIN_Q8_RST;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            p_reg          <= p_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            step_cnt_reg   <= step_cnt_next;
            load_idx_reg   <= load_idx_next;
            emit_idx_reg   <= emit_idx_next;
            time_steps_reg <= time_steps_next;
            gain_reg       <= gain_next;
        end
    end

    hds_ram #(
        .WIDTH (hds_pkg::TEMP_W),
        .DEPTH (hds_pkg::CELLS)
    ) u_grid_even (
        .clk   (clk),
        .we    (load_we || (step_we && src_odd)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_even)
    );

    hds_ram #(
        .WIDTH (hds_pkg::TEMP_W),
        .DEPTH (hds_pkg::CELLS)
    ) u_grid_odd (
        .clk   (clk),
        .we    (load_we || (step_we && !src_odd)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_odd)
    );

    hds_alu u_alu (
        .clk    (clk),
        .ctrl   (alu_ctrl),
        .rdata  (src_data),
        .gain   (gain_reg),
        .result (alu_result)
    );

    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("load accepted while results are pending");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_ch.load_last |=> !in_ch.ready)
        else $error("load_last did not start the run");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && out_ch.out_last |=> in_ch.ready && !out_ch.valid)
        else $error("block not idle after the last result");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> row_reg != '0 && col_reg != '0
                                 && row_reg <= ROW_END && col_reg <= COL_END)
        else $error("stencil cursor left the interior");

    a_step_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> step_cnt_reg < time_steps_reg)
        else $error("step counter ran past time_steps");

endmodule

`default_nettype wire

// File: dv/tb_heat_diffusion_stencil_grid.sv
// Testbench for the heat diffusion stencil grid: directed and random grids against a local predictor.
module tb_heat_diffusion_stencil_grid;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hds_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [hds_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int TEMP_MAX      = (1 << hds_pkg::TEMP_W) - 1;
    localparam int TEMP_TOP      = 100;
    localparam int RANDOM_ITEMS  = 50;
    localparam int LONG_STALL    = 500;
    localparam int STALL_AFTER   = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    typedef enum {FILL_FLAT, FILL_CHECKER, FILL_RAMP, FILL_HOT, FILL_NOISE} fill_kind_t;

    typedef struct {
        bit                             cfg_wr;
        logic [hds_pkg::CFG_DATA_W-1:0] steps_data;
        logic [hds_pkg::CFG_DATA_W-1:0] gain_data;
        bit                             spare_wr;
        int                             count;
        fill_kind_t                     kind;
        hds_pkg::temp_t                 level;
        bit                             flat_known;
    } grid_row_t;

    typedef struct packed {
        hds_pkg::temp_t temp;
        logic           last;
    } cell_out_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hds_pkg::CFG_DATA_W-1:0] cfg_data;

    hds_in_if  in_ch();
    hds_out_if out_ch();

    heat_diffusion_stencil_grid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Diffusion predictor state
    hds_pkg::temp_t              grid_buf [2][hds_pkg::CELLS];
    int                          load_pos;
    logic [hds_pkg::STEPS_W-1:0] steps_cfg;
    logic [hds_pkg::GAIN_W-1:0]  gain_cfg;
    bit                          flat_known;
    hds_pkg::temp_t              flat_level;
    cell_out_t                   cells_due [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int cells_taken;
    int fail_cnt;

    // Directed grids: a flat grid at reset settings, then the register and load extremes
    grid_row_t directed_grids [7] = '{
        '{1'b0, 8'd0,   8'd0,   1'b0, hds_pkg::CELLS,     FILL_FLAT,    7'd100, 1'b1},
        '{1'b1, 8'd0,   8'd64,  1'b0, 24,                 FILL_NOISE,   7'd0,   1'b0},
        '{1'b1, 8'd1,   8'd64,  1'b0, hds_pkg::CELLS,     FILL_CHECKER, 7'd127, 1'b0},
        '{1'b1, 8'd255, 8'd0,   1'b0, 8,                  FILL_NOISE,   7'd0,   1'b0},
        '{1'b1, 8'd3,   8'hFF,  1'b1, 30,                 FILL_HOT,     7'd127, 1'b0},
        '{1'b1, 8'd2,   8'd64,  1'b0, hds_pkg::CELLS + 2, FILL_RAMP,    7'd0,   1'b0},
        '{1'b1, 8'd5,   8'd1,   1'b1, 1,                  FILL_NOISE,   7'd0,   1'b0}
    };

    function automatic void diffuse_once(int src);
        int p;
        int old;
        int nsum;
        int v;
        for (int r = 1; r < hds_pkg::ROWS - 1; r++)
        begin
            for (int c = 1; c < hds_pkg::COLS - 1; c++)
            begin
                p    = r * hds_pkg::COLS + c;
                old  = int'(grid_buf[src][p]);
                nsum = int'(grid_buf[src][p - hds_pkg::COLS])
                     + int'(grid_buf[src][p + hds_pkg::COLS])
                     + int'(grid_buf[src][p - 1]) + int'(grid_buf[src][p + 1]);
                // arithmetic shift floors toward minus infinity
                v = old + ((int'(gain_cfg) * (nsum - 4 * old)) >>> hds_pkg::Q_SHIFT);
                if (v < 0)
                    v = 0;
                if (v > TEMP_MAX)
                    v = TEMP_MAX;
                grid_buf[1 - src][p] = hds_pkg::temp_t'(v);
            end
        end
    endfunction

    function automatic void predict_cell(hds_pkg::temp_t t, logic last);
        int        fin;
        cell_out_t e;
        grid_buf[0][load_pos] = t;
        grid_buf[1][load_pos] = t;
        load_pos = (load_pos + 1) % hds_pkg::CELLS;
        if (!last)
            return;
        for (int k = 0; k < int'(steps_cfg); k++)
            diffuse_once(k % 2);
        fin = int'(steps_cfg[0]);
        for (int p = 0; p < hds_pkg::CELLS; p++)
        begin
            e.temp = flat_known ? flat_level : grid_buf[fin][p];
            e.last = (p == hds_pkg::CELLS - 1);
            cells_due.push_back(e);
        end
        load_pos = 0;
    endfunction

    function automatic void shadow_reg(logic [hds_pkg::CFG_IDX_W-1:0] idx,
                                       logic [hds_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            hds_pkg::CFG_TIME_STEPS: steps_cfg = d[hds_pkg::STEPS_W-1:0];
            hds_pkg::CFG_GAIN_Q8:    gain_cfg  = d[hds_pkg::GAIN_W-1:0];
            default:                 ;
        endcase
    endfunction

    function automatic hds_pkg::temp_t fill_value(fill_kind_t kind, hds_pkg::temp_t level,
                                                  int pos);
        case (kind)
            FILL_FLAT:    return level;
            FILL_CHECKER: return ((pos / hds_pkg::COLS + pos % hds_pkg::COLS) % 2 == 0)
                                 ? level : hds_pkg::temp_t'(0);
            FILL_RAMP:    return hds_pkg::temp_t'((pos * 2) % (TEMP_MAX + 1));
            FILL_HOT:     return (pos == (hds_pkg::ROWS / 2) * hds_pkg::COLS + hds_pkg::COLS / 2)
                                 ? level : hds_pkg::temp_t'(0);
            default:
                if ($urandom_range(0, 3) == 0)
                    return hds_pkg::temp_t'($urandom_range(0, TEMP_MAX));
                else
                    return hds_pkg::temp_t'($urandom_range(0, TEMP_TOP));
        endcase
    endfunction

    task automatic push_cell(hds_pkg::temp_t t, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.cell_temp <= hds_pkg::temp_t'($urandom);
            in_ch.load_last <= 1'($urandom);
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cell_temp <= t;
        in_ch.load_last <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_cell(t, last);
    endtask

    task automatic push_grid(int count, fill_kind_t kind, hds_pkg::temp_t level);
        for (int pos = 0; pos < count; pos++)
            push_cell(fill_value(kind, level, pos % hds_pkg::CELLS), pos == count - 1);
    endtask

    // Drop valid and hold until every expected cell is out and the block settles
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [hds_pkg::CFG_DATA_W-1:0] steps_d,
                             logic [hds_pkg::CFG_DATA_W-1:0] gain_d, bit spare);
        logic [hds_pkg::CFG_DATA_W-1:0] junk;
        junk      = hds_pkg::CFG_DATA_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= hds_pkg::CFG_TIME_STEPS;
        cfg_data  <= steps_d;
        shadow_reg(hds_pkg::CFG_TIME_STEPS, steps_d);
        @(posedge clk);
        cfg_index <= hds_pkg::CFG_GAIN_Q8;
        cfg_data  <= gain_d;
        shadow_reg(hds_pkg::CFG_GAIN_Q8, gain_d);
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= CFG_SPARE_LO;
            cfg_data  <= junk;
            @(posedge clk);
            cfg_index <= CFG_SPARE_HI;
            cfg_data  <= ~junk;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                tx_idle_pct = 23;
                rx_idle_pct = 85;
            end
            1:
            begin
                tx_idle_pct = 85;
                rx_idle_pct = 23;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    task automatic take_cell();
        cell_out_t want;
        cells_taken++;
        if (cells_due.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
                $display("unexpected result: temp %0d last %0d", out_ch.out_temp, out_ch.out_last);
            return;
        end
        want = cells_due.pop_front();
        if (out_ch.out_temp !== want.temp || out_ch.out_last !== want.last)
        begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
                $display("result %0d: expected temp %0d last %0d, got temp %0d last %0d",
                         cells_taken, want.temp, want.last, out_ch.out_temp, out_ch.out_last);
        end
    endtask

    initial
    begin : sender
        int             rand_items;
        int             count;
        int             waited;
        fill_kind_t     kind;
        hds_pkg::temp_t level;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cell_temp <= '0;
        in_ch.load_last <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= hds_pkg::CFG_TIME_STEPS;
        cfg_data        <= '0;
        load_pos   = 0;
        steps_cfg  = hds_pkg::TIME_STEPS_RST;
        gain_cfg   = hds_pkg::GAIN_Q8_RST;
        flat_known = 1'b0;
        flat_level = '0;
        fail_cnt   = 0;
        set_idling(0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_grids[i])
        begin
            if (directed_grids[i].cfg_wr)
            begin
                wait_idle();
                write_cfg(directed_grids[i].steps_data, directed_grids[i].gain_data,
                          directed_grids[i].spare_wr);
            end
            flat_known = directed_grids[i].flat_known;
            flat_level = directed_grids[i].level;
            push_grid(directed_grids[i].count, directed_grids[i].kind, directed_grids[i].level);
        end
        flat_known = 1'b0;

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items < RANDOM_ITEMS / 3)
                set_idling(0);
            else if (rand_items < 2 * RANDOM_ITEMS / 3)
                set_idling(1);
            else
                set_idling(2);
            // the first random grid queues up behind the last directed readout
            if (rand_items > 0 && $urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_cfg(($urandom_range(0, 7) == 0)
                              ? hds_pkg::CFG_DATA_W'($urandom_range(10, 24))
                              : hds_pkg::CFG_DATA_W'($urandom_range(0, 9)),
                          ($urandom_range(0, 3) == 0)
                              ? hds_pkg::CFG_DATA_W'($urandom_range(0, 255))
                              : hds_pkg::CFG_DATA_W'($urandom_range(0, 64)),
                          $urandom_range(0, 5) == 0);
            end
            // mostly short loads; now and then a full grid or one that wraps
            case ($urandom_range(0, 15))
                0:       count = hds_pkg::CELLS + $urandom_range(1, 12);
                1, 2:    count = hds_pkg::CELLS;
                default: count = $urandom_range(1, 20);
            endcase
            kind  = ($urandom_range(0, 3) != 0) ? FILL_NOISE : fill_kind_t'($urandom_range(0, 4));
            level = hds_pkg::temp_t'($urandom_range(0, TEMP_MAX));
            push_grid(count, kind, level);
            rand_items += count;
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        while (cells_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (cells_due.size() != 0)
        begin
            fail_cnt++;
            $display("%0d expected results never arrived", cells_due.size());
        end
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : receiver
        bit stall_done;
        stall_done   = 1'b0;
        cells_taken  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                take_cell();
            // hold off once mid-readout while the next load is waiting
            if (!stall_done && cells_taken >= STALL_AFTER
                && out_ch.valid === 1'b1 && in_ch.valid === 1'b1)
            begin
                stall_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin : watchdog
        #(100_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
